[src/tae_pkg.sv]
// Shared constants for the throttle acceleration enrichment block.
// No dependencies; imported by tae_div and throttle_accel_enrichment.
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

  // field widths
  localparam int unsigned POS_W    = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned REG_W    = 16;
  localparam int unsigned ENRICH_W = 12;
  localparam int unsigned HOLD_W   = 8;

  // serial divider: dividend/quotient width; holds delta*1000 and the clamped product
  localparam int unsigned DIV_W = 20;

  localparam int unsigned MIN_DT_MS    = 10;
  localparam int unsigned RATE_SCALE   = 1000;
  localparam int unsigned GAIN_DIVISOR = 500;
  localparam int unsigned ENRICH_MAX   = 2048;
  // largest product whose quotient by the divisor still saturates to ENRICH_MAX
  localparam int unsigned PROD_CLAMP   = (ENRICH_MAX + 1) * GAIN_DIVISOR - 1;

  localparam int unsigned HOLD_SAMPLES_DEF = 16;

  // configuration register indexes
  localparam logic REG_RATE_THRESHOLD = 1'b0;
  localparam logic REG_ENRICH_GAIN    = 1'b1;

  localparam logic [REG_W-1:0] RATE_THRESHOLD_RST = 16'd1000;
  localparam logic [REG_W-1:0] ENRICH_GAIN_RST    = 16'd256;

endpackage : tae_pkg

`default_nettype wire

[src/tae_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on tae_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module tae_div #(
  parameter int unsigned DIV_W = tae_pkg::DIV_W,
  parameter int unsigned DSR_W = tae_pkg::TIME_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DIV_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dq_q, dq_d;     // dividend bits out at the top, quotient bits in below
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DIV_W-1:0] cand;
  logic             ge;

  // remainder never exceeds the dividend bits taken so far, so the top bit drops safely
  assign cand = {rem_q[DIV_W-2:0], dq_q[DIV_W-1]};
  assign ge   = (dsr_q[DSR_W-1:DIV_W] == '0) && (cand >= dsr_q[DIV_W-1:0]);

  always_comb begin
    rem_d  = rem_q;
    dq_d   = dq_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dq_d   = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (cand - dsr_q[DIV_W-1:0]) : cand;
      dq_d  = {dq_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule : tae_div

`default_nettype wire

[src/throttle_accel_enrichment.sv]
// Throttle acceleration enrichment: throttle rate, threshold, gain, hold count.
// Depends on tae_pkg and tae_div.
//
// Usage:
//   Slave stream takes one throttle sample per request: position and ms timestamp.
//   Master stream returns one result per sample: enrichment, hold count in tdata,
//   and in tuser whether it was used (at least 10 ms after the last used one).
//   Config port: cfg_we_i writes rate_threshold (index 0) or enrich_gain (index 1).
// Timing:
//   One sample at a time. A too-early sample, or one with no throttle rise,
//   goes to the emit state, which registers its result once the output register
//   is free; input is ready again as that result turns valid. A rising sample
//   first runs the shared bit-serial divider for the rate. A rate above threshold
//   adds a serial multiply by the gain and a divide by 500 on the same divider;
//   every path ends in the emit state, and input is ready again as it goes idle.
//   The divider width (20 quotient bits) and gain width set how long these run.
// Reset clears the reference sample, enrichment, hold count and loads the
// register defaults. A stalled receiver holds the result in the output
// register; the next sample is still taken, and its result waits until the
// output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module throttle_accel_enrichment #(
  parameter int unsigned HOLD_SAMPLES = tae_pkg::HOLD_SAMPLES_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // throttle_pos [9:0], time_ms [41:10], zero pad [47:42]
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic             [47:0] s_axis_tdata,
  // enrich_amount [11:0], hold_left [19:12], zero pad [23:20]
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic                  [23:0] m_axis_tdata,
  // accepted [0]
  output logic                         m_axis_tuser,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [tae_pkg::REG_W-1:0] cfg_wdata_i
);

  import tae_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_RATE = 3'd1;
  localparam logic [2:0] ST_MUL      = 3'd2;
  localparam logic [2:0] ST_DIV_AMT  = 3'd3;
  localparam logic [2:0] ST_EMIT     = 3'd4;

  localparam int unsigned MCNT_W = $clog2(REG_W + 1);
  localparam int unsigned SUM_W  = DIV_W + 2;

  logic [2:0]          state_q, state_d;
  logic [REG_W-1:0]    thr_q, gain_q;
  logic [POS_W-1:0]    prev_pos_q, prev_pos_d;
  logic [TIME_W-1:0]   prev_time_q, prev_time_d;
  logic [ENRICH_W-1:0] enrich_q, enrich_d;
  logic [HOLD_W-1:0]   hold_q, hold_d;

  logic                used_q, used_d;
  logic                above_q, above_d;
  logic [ENRICH_W-1:0] amt_q, amt_d;
  logic [DIV_W-1:0]    excess_q, excess_d;
  logic [DIV_W-1:0]    acc_q, acc_d;
  logic [REG_W-1:0]    gain_sh_q, gain_sh_d;
  logic [MCNT_W-1:0]   mcnt_q, mcnt_d;
  logic                div_go_q, div_go_d;

  logic                out_valid_q, out_valid_d;
  logic                out_used_q, out_used_d;
  logic [ENRICH_W-1:0] out_enrich_q, out_enrich_d;
  logic [HOLD_W-1:0]   out_hold_q, out_hold_d;

  logic [POS_W-1:0]    in_pos;
  logic [TIME_W-1:0]   in_time, dt;
  logic [DIV_W-1:0]    num;
  logic                in_acc;

  logic                div_start, div_done;
  logic [DIV_W-1:0]    div_dividend, div_quotient;
  logic [TIME_W-1:0]   div_divisor;
  logic [SUM_W-1:0]    mul_sum;

  assign in_pos  = s_axis_tdata[POS_W-1:0];
  assign in_time = s_axis_tdata[POS_W+TIME_W-1:POS_W];
  assign dt      = in_time - prev_time_q;
  assign num     = DIV_W'(in_pos - prev_pos_q) * DIV_W'(RATE_SCALE);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // divider serves the rate first, then the product divided by the gain divisor
  always_comb begin
    if (state_q == ST_IDLE) begin
      div_dividend = num;
      div_divisor  = dt;
    end else begin
      div_dividend = acc_q;
      div_divisor  = TIME_W'(GAIN_DIVISOR);
    end
  end

  assign div_start = (in_acc && (dt >= TIME_W'(MIN_DT_MS)) && (in_pos > prev_pos_q))
                     || div_go_q;

  tae_div #(
    .DIV_W(DIV_W),
    .DSR_W(TIME_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  // MSB-first shift-add, saturated so the later divide still yields ENRICH_MAX
  assign mul_sum = {1'b0, acc_q, 1'b0} + (gain_sh_q[REG_W-1] ? SUM_W'(excess_q) : '0);

  always_comb begin
    state_d      = state_q;
    prev_pos_d   = prev_pos_q;
    prev_time_d  = prev_time_q;
    enrich_d     = enrich_q;
    hold_d       = hold_q;
    used_d       = used_q;
    above_d      = above_q;
    amt_d        = amt_q;
    excess_d     = excess_q;
    acc_d        = acc_q;
    gain_sh_d    = gain_sh_q;
    mcnt_d       = mcnt_q;
    div_go_d     = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_used_d   = out_used_q;
    out_enrich_d = out_enrich_q;
    out_hold_d   = out_hold_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          above_d = 1'b0;
          if (dt >= TIME_W'(MIN_DT_MS)) begin
            used_d      = 1'b1;
            prev_pos_d  = in_pos;
            prev_time_d = in_time;
            // no rise means rate <= 0, never above threshold
            state_d     = (in_pos > prev_pos_q) ? ST_DIV_RATE : ST_EMIT;
          end else begin
            used_d  = 1'b0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_DIV_RATE: begin
        if (div_done) begin
          if (div_quotient > DIV_W'(thr_q)) begin
            above_d   = 1'b1;
            excess_d  = div_quotient - DIV_W'(thr_q);
            acc_d     = '0;
            gain_sh_d = gain_q;
            mcnt_d    = MCNT_W'(REG_W);
            state_d   = ST_MUL;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        acc_d     = (mul_sum > SUM_W'(PROD_CLAMP)) ? DIV_W'(PROD_CLAMP) : mul_sum[DIV_W-1:0];
        gain_sh_d = {gain_sh_q[REG_W-2:0], 1'b0};
        mcnt_d    = mcnt_q - 1'b1;
        if (mcnt_q == MCNT_W'(1)) begin
          div_go_d = 1'b1;
          state_d  = ST_DIV_AMT;
        end
      end
      ST_DIV_AMT: begin
        if (div_done) begin
          amt_d   = div_quotient[ENRICH_W-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          if (used_q) begin
            if (above_q) begin
              enrich_d = amt_q;
              hold_d   = HOLD_W'(HOLD_SAMPLES);
            end else if (hold_q != '0) begin
              hold_d = hold_q - 1'b1;
              if (hold_q == HOLD_W'(1)) begin
                enrich_d = '0;
              end
            end
          end
          out_valid_d  = 1'b1;
          out_used_d   = used_q;
          out_enrich_d = enrich_d;
          out_hold_d   = hold_d;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= RATE_THRESHOLD_RST;
      gain_q      <= ENRICH_GAIN_RST;
      prev_pos_q  <= '0;
      prev_time_q <= '0;
      enrich_q    <= '0;
      hold_q      <= '0;
      mcnt_q      <= '0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_pos_q  <= prev_pos_d;
      prev_time_q <= prev_time_d;
      enrich_q    <= enrich_d;
      hold_q      <= hold_d;
      mcnt_q      <= mcnt_d;
      div_go_q    <= div_go_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RATE_THRESHOLD: thr_q  <= cfg_wdata_i;
          REG_ENRICH_GAIN:    gain_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    used_q       <= used_d;
    above_q      <= above_d;
    amt_q        <= amt_d;
    excess_q     <= excess_d;
    acc_q        <= acc_d;
    gain_sh_q    <= gain_sh_d;
    out_used_q   <= out_used_d;
    out_enrich_q <= out_enrich_d;
    out_hold_q   <= out_hold_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_hold_q, out_enrich_q};
  assign m_axis_tuser  = out_used_q;

endmodule : throttle_accel_enrichment

`default_nettype wire
